/* sv/sbrc_pkg.sv */
// Shared types, field widths, command codes and register map constants
// for the SPI banked register command unit. No dependencies.
`default_nettype none

package sbrc_pkg;

    typedef logic [7:0] byte_t;

    localparam int CMD_W  = 3;
    localparam int ADDR_W = 5;
    localparam int DATA_W = 8;
    localparam int PTR_W  = 16;

    localparam logic [CMD_W-1:0] CMD_RD_CTRL   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_RD_BUF    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_WR_CTRL   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_WR_BUF    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_BIT_SET   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_BIT_CLR   = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SOFT_RST  = 3'd6;

    localparam int BANKED_COUNT = 27;
    localparam int COMMON_COUNT = 5;
    localparam int IDX_CTL2     = 3;
    localparam int IDX_CTL1     = 4;
    localparam int AUTOINC_POS  = 7;
    localparam byte_t CTL2_RESET = 8'h80;

    localparam int BUFFER_DEPTH_DEF = 8192;
    localparam int NUM_BANKS_DEF    = 4;

endpackage

`default_nettype wire

/* sv/sbrc_if.sv */
// Valid/ready channel interfaces for command and response transfers.
// Depends on sbrc_pkg for field widths.
`default_nettype none

interface sbrc_req_if;
    logic                           valid;
    logic                           ready;
    logic [sbrc_pkg::CMD_W-1:0]     command;
    logic [sbrc_pkg::ADDR_W-1:0]    reg_addr;
    logic [sbrc_pkg::DATA_W-1:0]    data_in;
    logic                           end_of_transaction;

    modport source (output valid, command, reg_addr, data_in, end_of_transaction,
                    input ready);
    modport sink   (input valid, command, reg_addr, data_in, end_of_transaction,
                    output ready);
endinterface

interface sbrc_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [sbrc_pkg::DATA_W-1:0]    read_data;
    logic                           read_valid;

    modport source (output valid, read_data, read_valid, input ready);
    modport sink   (input valid, read_data, read_valid, output ready);
endinterface

`default_nettype wire

/* sv/sbrc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Read of an address written at the same edge returns the old contents.
`default_nettype none

module sbrc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* sv/spi_banked_register_command_unit.sv */
// Top level of the SPI banked register command unit: register file, pointers,
// packet buffer. Depends on sbrc_pkg, sbrc_if.sv and sbrc_ram.
//
//  channel | dir | payload                                        | transfer
//  req     | in  | command, reg_addr, data_in, end_of_transaction | valid & ready
//  rsp     | out | read_data, read_valid                          | valid & ready
//
// One command per clock sustained while rsp accepts responses; each command passes
// through the RAM read at transfer, the execute stage and the response register.
// The banked registers and packet buffer sit in registered-read RAMs; a write
// from the executing command is forwarded to a read issued at the same edge.
// Reset and soft reset clear registers at once through per-entry valid bits.
// A stalled rsp holds the execute stage; req is still taken while it is empty.
`default_nettype none

module spi_banked_register_command_unit #(
    parameter int BUFFER_DEPTH = sbrc_pkg::BUFFER_DEPTH_DEF,
    parameter int NUM_BANKS    = sbrc_pkg::NUM_BANKS_DEF
) (
    input wire logic  clk,
    input wire logic  rst_n,
    sbrc_req_if.sink  req,
    sbrc_rsp_if.source rsp
);

    localparam int BANKED_DEPTH = NUM_BANKS * sbrc_pkg::BANKED_COUNT;
    localparam int BIDX_W       = $clog2(BANKED_DEPTH);
    localparam int PMEM_AW      = $clog2(BUFFER_DEPTH);
    localparam int PW           = sbrc_pkg::PTR_W;

    // execute stage
    logic                          s1_valid_reg;
    logic [sbrc_pkg::CMD_W-1:0]    s1_cmd_reg;
    logic [sbrc_pkg::ADDR_W-1:0]   s1_addr_reg;
    sbrc_pkg::byte_t               s1_data_reg;
    logic [BIDX_W-1:0]             s1_idx_reg;
    logic                          bbyp_hit_reg;
    sbrc_pkg::byte_t               bbyp_data_reg;
    logic                          pbyp_hit_reg;
    sbrc_pkg::byte_t               pbyp_data_reg;

    // architectural state
    sbrc_pkg::byte_t               common_reg [sbrc_pkg::COMMON_COUNT];
    sbrc_pkg::byte_t               common_next [sbrc_pkg::COMMON_COUNT];
    logic [PW-1:0]                 ptr_rd_reg, ptr_rd_next;
    logic [PW-1:0]                 ptr_wr_reg, ptr_wr_next;
    logic [BANKED_DEPTH-1:0]       valid_reg;

    // response register
    logic                          out_valid_reg;
    sbrc_pkg::byte_t               out_rdata_reg;
    logic                          out_rvalid_reg;

    logic                          s1_commit;
    logic                          accept;
    sbrc_pkg::byte_t               bram_q, pmem_q;
    logic                          bram_we, pmem_we, valid_clr;
    sbrc_pkg::byte_t               cur_val, wr_val, rsp_data;
    logic                          rsp_rvalid;
    logic                          is_common, bank_ok, is_ptr, autoinc;
    logic [2:0]                    cidx;
    logic [1:0]                    bank;
    logic                          rd_in_range, wr_in_range;
    logic [1:0]                    in_bank;
    logic [BIDX_W-1:0]             in_idx;
    logic [PMEM_AW-1:0]            in_paddr;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        logic [PW:0] nxt;
        nxt = {1'b0, p} + (PW+1)'(1);
        return (nxt >= (PW+1)'(BUFFER_DEPTH)) ? '0 : nxt[PW-1:0];
    endfunction

    assign s1_commit = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || s1_commit;
    assign accept    = req.valid && req.ready;

    // decode of the executing command against committed state
    assign is_common   = s1_addr_reg >= sbrc_pkg::ADDR_W'(sbrc_pkg::BANKED_COUNT);
    assign cidx        = 3'(s1_addr_reg - sbrc_pkg::ADDR_W'(sbrc_pkg::BANKED_COUNT));
    assign bank        = common_reg[sbrc_pkg::IDX_CTL1][1:0];
    assign bank_ok     = 3'(bank) < 3'(NUM_BANKS);
    assign is_ptr      = (bank == 2'd0) && (s1_addr_reg[4:2] == 3'd0);
    assign autoinc     = common_reg[sbrc_pkg::IDX_CTL2][sbrc_pkg::AUTOINC_POS];
    assign rd_in_range = {1'b0, ptr_rd_reg} < (PW+1)'(BUFFER_DEPTH);
    assign wr_in_range = {1'b0, ptr_wr_reg} < (PW+1)'(BUFFER_DEPTH);

    always_comb
    begin
        cur_val = '0;
        if (is_common)
        begin
            cur_val = common_reg[cidx];
        end
        else if (bank_ok && is_ptr)
        begin
            case (s1_addr_reg[1:0])
                2'd0:    cur_val = ptr_rd_reg[7:0];
                2'd1:    cur_val = ptr_rd_reg[15:8];
                2'd2:    cur_val = ptr_wr_reg[7:0];
                default: cur_val = ptr_wr_reg[15:8];
            endcase
        end
        else if (bank_ok)
        begin
            if (bbyp_hit_reg)
            begin
                cur_val = bbyp_data_reg;
            end
            else if (valid_reg[s1_idx_reg])
            begin
                cur_val = bram_q;
            end
        end
    end

    always_comb
    begin
        case (s1_cmd_reg)
            sbrc_pkg::CMD_BIT_SET: wr_val = cur_val | s1_data_reg;
            sbrc_pkg::CMD_BIT_CLR: wr_val = cur_val & ~s1_data_reg;
            default:               wr_val = s1_data_reg;
        endcase
    end

    always_comb
    begin
        common_next = common_reg;
        ptr_rd_next = ptr_rd_reg;
        ptr_wr_next = ptr_wr_reg;
        bram_we     = 1'b0;
        pmem_we     = 1'b0;
        valid_clr   = 1'b0;
        rsp_data    = '0;
        rsp_rvalid  = 1'b0;
        if (s1_commit)
        begin
            case (s1_cmd_reg)
                sbrc_pkg::CMD_RD_CTRL:
                begin
                    rsp_data   = cur_val;
                    rsp_rvalid = 1'b1;
                end
                sbrc_pkg::CMD_RD_BUF:
                begin
                    rsp_rvalid = 1'b1;
                    if (rd_in_range)
                    begin
                        rsp_data = pbyp_hit_reg ? pbyp_data_reg : pmem_q;
                    end
                    if (autoinc)
                    begin
                        ptr_rd_next = ptr_inc(ptr_rd_reg);
                    end
                end
                sbrc_pkg::CMD_WR_BUF:
                begin
                    pmem_we = wr_in_range;
                    if (autoinc)
                    begin
                        ptr_wr_next = ptr_inc(ptr_wr_reg);
                    end
                end
                sbrc_pkg::CMD_WR_CTRL, sbrc_pkg::CMD_BIT_SET, sbrc_pkg::CMD_BIT_CLR:
                begin
                    if (is_common)
                    begin
                        common_next[cidx] = wr_val;
                    end
                    else if (bank_ok && is_ptr)
                    begin
                        case (s1_addr_reg[1:0])
                            2'd0:    ptr_rd_next[7:0]  = wr_val;
                            2'd1:    ptr_rd_next[15:8] = wr_val;
                            2'd2:    ptr_wr_next[7:0]  = wr_val;
                            default: ptr_wr_next[15:8] = wr_val;
                        endcase
                    end
                    else if (bank_ok)
                    begin
                        bram_we = 1'b1;
                    end
                end
                sbrc_pkg::CMD_SOFT_RST:
                begin
                    for (int i = 0; i < sbrc_pkg::COMMON_COUNT; i++)
                    begin
                        common_next[i] = (i == sbrc_pkg::IDX_CTL2) ? sbrc_pkg::CTL2_RESET
                                                                   : '0;
                    end
                    ptr_rd_next = '0;
                    ptr_wr_next = '0;
                    valid_clr   = 1'b1;
                end
                default:
                begin
                    rsp_rvalid = 1'b0;
                end
            endcase
        end
    end

    // read addresses for the incoming command see the executing command's effect
    assign in_bank  = common_next[sbrc_pkg::IDX_CTL1][1:0];
    assign in_idx   = BIDX_W'(32'(in_bank) * sbrc_pkg::BANKED_COUNT + 32'(req.reg_addr));
    assign in_paddr = ptr_rd_next[PMEM_AW-1:0];

    sbrc_ram #(
        .WIDTH (8),
        .DEPTH (BANKED_DEPTH)
    ) u_bank_ram (
        .clk   (clk),
        .we    (bram_we),
        .waddr (s1_idx_reg),
        .wdata (wr_val),
        .re    (accept),
        .raddr (in_idx),
        .rdata (bram_q)
    );

    sbrc_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_DEPTH)
    ) u_pkt_ram (
        .clk   (clk),
        .we    (pmem_we),
        .waddr (ptr_wr_reg[PMEM_AW-1:0]),
        .wdata (s1_data_reg),
        .re    (accept),
        .raddr (in_paddr),
        .rdata (pmem_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            ptr_rd_reg    <= '0;
            ptr_wr_reg    <= '0;
            valid_reg     <= '0;
            for (int i = 0; i < sbrc_pkg::COMMON_COUNT; i++)
            begin
                common_reg[i] <= (i == sbrc_pkg::IDX_CTL2) ? sbrc_pkg::CTL2_RESET : '0;
            end
        end
        else
        begin
            common_reg  <= common_next;
            ptr_rd_reg  <= ptr_rd_next;
            ptr_wr_reg  <= ptr_wr_next;
            if (valid_clr)
            begin
                valid_reg <= '0;
            end
            else if (bram_we)
            begin
                valid_reg[s1_idx_reg] <= 1'b1;
            end

            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_commit)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload: capture command and forwarding data at transfer, response data at commit
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cmd_reg    <= req.command;
            s1_addr_reg   <= req.reg_addr;
            s1_data_reg   <= req.data_in;
            s1_idx_reg    <= in_idx;
            bbyp_hit_reg  <= bram_we && (s1_idx_reg == in_idx);
            bbyp_data_reg <= wr_val;
            pbyp_hit_reg  <= pmem_we && (ptr_wr_reg[PMEM_AW-1:0] == in_paddr);
            pbyp_data_reg <= s1_data_reg;
        end
        if (s1_commit)
        begin
            out_rdata_reg  <= rsp_data;
            out_rvalid_reg <= rsp_rvalid;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.read_data  = out_rdata_reg;
    assign rsp.read_valid = out_rvalid_reg;

    a_soft_reset_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_commit && s1_cmd_reg == sbrc_pkg::CMD_SOFT_RST) |=>
            (valid_reg == '0 && ptr_rd_reg == '0 && ptr_wr_reg == '0 &&
             common_reg[sbrc_pkg::IDX_CTL2] == sbrc_pkg::CTL2_RESET))
        else $error("soft reset left register state behind");

    a_write_no_read: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_commit && (s1_cmd_reg == sbrc_pkg::CMD_WR_CTRL ||
                       s1_cmd_reg == sbrc_pkg::CMD_WR_BUF)) |=>
            (rsp.valid && !rsp.read_valid && rsp.read_data == '0))
        else $error("write command produced read data");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_commit) |=> (s1_valid_reg && $stable(s1_cmd_reg)))
        else $error("execute stage lost a command under stall");

    a_oob_write_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_commit && s1_cmd_reg == sbrc_pkg::CMD_WR_BUF && !wr_in_range) |-> !pmem_we)
        else $error("out-of-range buffer write reached memory");

endmodule

`default_nettype wire
